/* rtl/assert_macros.svh */
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SJQ_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define SJQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/sjq_pkg.sv */
// Shared constants, codes and types of the sorted job queue.
`default_nettype none

package sjq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int KEY_W       = 16;
  localparam int PID_W       = 22;
  localparam int STATUS_W    = 2;
  localparam int ENTRY_W     = 5;

  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DELETE = 1'b1;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] key;
    logic [PID_W-1:0] pid;
  } req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wkey;
    logic [PID_W-1:0] wpid;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_cmd_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PID_W-1:0] pid;
  } mem_rd_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CNT_W-1:0]    count;
  } res_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } seq_stat_t;

endpackage

`default_nettype wire

/* rtl/sjq_store.sv */
// Job table memory: one write port and one registered read port.
`default_nettype none

module sjq_store import sjq_pkg::*; (
  input  logic     clk,
  input  mem_cmd_t cmd,
  output mem_rd_t  rd
);

  logic [KEY_W-1:0] slot_key [QUEUE_DEPTH];
  logic [PID_W-1:0] slot_pid [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      slot_key[cmd.waddr] <= cmd.wkey;
      slot_pid[cmd.waddr] <= cmd.wpid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rd.key <= slot_key[cmd.raddr];
      rd.pid <= slot_pid[cmd.raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/sjq_cmp.sv */
// Shared key comparator used on the insert and delete search steps of the table walk.
`default_nettype none

module sjq_cmp import sjq_pkg::*; (
  input  logic [KEY_W-1:0] slot,
  input  logic [KEY_W-1:0] probe,
  output cmp_t             res
);

  assign res.lt = (slot < probe);
  assign res.eq = (slot == probe);

endmodule

`default_nettype wire

/* rtl/sjq_seq.sv */
// Sequencer that walks the job table one slot at a time per request.
`default_nettype none

module sjq_seq import sjq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  req_t      req_in,
  input  logic      res_take,
  output seq_stat_t stat,
  output res_t      res
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_INS_STEP = 3'd1;
  localparam logic [2:0] S_INS_CHK  = 3'd2;
  localparam logic [2:0] S_DEL_STEP = 3'd3;
  localparam logic [2:0] S_DEL_CHK  = 3'd4;
  localparam logic [2:0] S_SH_STEP  = 3'd5;
  localparam logic [2:0] S_SH_WR    = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]          state, state_next;
  logic [CNT_W-1:0]    ptr, ptr_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [STATUS_W-1:0] status_r, status_next;
  req_t                req, req_next;
  logic [CNT_W-1:0]    ptr_inc;
  mem_cmd_t            cmd;
  mem_rd_t             rd;
  cmp_t                cmp;

  sjq_store u_store (
    .clk (clk),
    .cmd (cmd),
    .rd  (rd)
  );

  sjq_cmp u_cmp (
    .slot  (rd.key),
    .probe (req.key),
    .res   (cmp)
  );

  assign ptr_inc = ptr + CNT_W'(1);

  always_comb begin
    state_next  = state;
    ptr_next    = ptr;
    count_next  = count;
    status_next = status_r;
    req_next    = req;
    cmd         = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next = req_in;
          if (req_in.req_type == REQ_INSERT) begin
            if (count == CNT_W'(QUEUE_DEPTH)) begin
              status_next = STATUS_FULL;
              state_next  = S_DONE;
            end else begin
              ptr_next   = count;
              state_next = S_INS_STEP;
            end
          end else begin
            ptr_next   = '0;
            state_next = S_DEL_STEP;
          end
        end
      end
      S_INS_STEP: begin
        if (ptr == '0) begin
          cmd.we      = 1'b1;
          cmd.waddr   = '0;
          cmd.wkey    = req.key;
          cmd.wpid    = req.pid;
          count_next  = count + CNT_W'(1);
          status_next = STATUS_DONE;
          state_next  = S_DONE;
        end else begin
          cmd.re     = 1'b1;
          cmd.raddr  = IDX_W'(ptr - CNT_W'(1));
          state_next = S_INS_CHK;
        end
      end
      S_INS_CHK: begin
        cmd.we    = 1'b1;
        cmd.waddr = IDX_W'(ptr);
        if (cmp.lt) begin
          cmd.wkey    = req.key;
          cmd.wpid    = req.pid;
          count_next  = count + CNT_W'(1);
          status_next = STATUS_DONE;
          state_next  = S_DONE;
        end else begin
          cmd.wkey   = rd.key;
          cmd.wpid   = rd.pid;
          ptr_next   = ptr - CNT_W'(1);
          state_next = S_INS_STEP;
        end
      end
      S_DEL_STEP: begin
        if (ptr == count) begin
          status_next = STATUS_NOT_FOUND;
          state_next  = S_DONE;
        end else begin
          cmd.re     = 1'b1;
          cmd.raddr  = IDX_W'(ptr);
          state_next = S_DEL_CHK;
        end
      end
      S_DEL_CHK: begin
        if (cmp.eq) begin
          state_next = S_SH_STEP;
        end else begin
          ptr_next   = ptr_inc;
          state_next = S_DEL_STEP;
        end
      end
      S_SH_STEP: begin
        if (ptr_inc >= count) begin
          count_next  = count - CNT_W'(1);
          status_next = STATUS_DONE;
          state_next  = S_DONE;
        end else begin
          cmd.re     = 1'b1;
          cmd.raddr  = IDX_W'(ptr_inc);
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        cmd.we     = 1'b1;
        cmd.waddr  = IDX_W'(ptr);
        cmd.wkey   = rd.key;
        cmd.wpid   = rd.pid;
        ptr_next   = ptr_inc;
        state_next = S_SH_STEP;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    status_r <= status_next;
    req      <= req_next;
  end

  assign stat.idle      = (state == S_IDLE);
  assign stat.res_valid = (state == S_DONE);
  assign res.status     = status_r;
  assign res.count      = count;

endmodule

`default_nettype wire

/* rtl/sorted_job_queue.sv */
// Top level of the sorted job queue: request intake and result register.
//
// Usage:
//   Request channel: in_valid / in_stall with req_type, job_key, job_pid.
//   A request is taken at a rising edge with in_valid high and in_stall low.
//   Insert (req_type 0) places the job ahead of the first stored job whose
//   key is not smaller; delete (req_type 1) removes the first job with an
//   equal key. Each request gives one result: status and entry_count.
//   Result channel: out_valid / out_stall with status and entry_count.
// Walk: the sequencer walks the table one slot at a time through a
//   single read port of the job memory: a step state reads a slot and a
//   check or write state then uses it; a refused insert walks no slot.
//   One request is in flight at a time: in_stall is high while it is worked.
// Reset: rst clears the entry count, the sequencer and out_valid.
// Stall: a result held by out_stall stays on the ports; the next request is
//   still accepted and worked, then waits in the sequencer until the result
//   register frees.
`default_nettype none

module sorted_job_queue import sjq_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                req_type,
  input  logic [KEY_W-1:0]    job_key,
  input  logic [PID_W-1:0]    job_pid,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [ENTRY_W-1:0]  entry_count
);

  logic      start;
  logic      res_take;
  req_t      req_in;
  seq_stat_t stat;
  res_t      res;

  // Take a new request only while the sequencer sits idle.
  assign in_stall = !stat.idle;
  assign start    = in_valid && !in_stall;

  assign req_in.req_type = req_type;
  assign req_in.key      = job_key;
  assign req_in.pid      = job_pid;

  sjq_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_in   (req_in),
    .res_take (res_take),
    .stat     (stat),
    .res      (res)
  );

  // Load the result register when it is empty or being drained this cycle.
  assign res_take = stat.res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Hold the payload while stalled; count is masked to the port width.
  always_ff @(posedge clk) begin
    if (res_take) begin
      status      <= res.status;
      entry_count <= ENTRY_W'(res.count);
    end
  end

endmodule

`default_nettype wire

/* rtl/sjq_chk.sv */
// Port-level checker for the sorted job queue and its bind.
`default_nettype none

`include "assert_macros.svh"

module sjq_chk import sjq_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                req_type,
  input logic [KEY_W-1:0]    job_key,
  input logic [PID_W-1:0]    job_pid,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic [ENTRY_W-1:0]  entry_count
);

  `SJQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(entry_count))
  `SJQ_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `SJQ_ASSERT_IMPL(a_full_count, clk, rst, out_valid && status == STATUS_FULL, entry_count == ENTRY_W'(QUEUE_DEPTH))
  `SJQ_ASSERT_IMPL(a_result_after_busy, clk, rst, $rose(out_valid), $past(in_stall))

endmodule

bind sorted_job_queue sjq_chk u_chk (.*);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the sorted job queue: directed table, then biased random requests.
`timescale 1ns / 1ps

module tb;
  import sjq_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 460;
  localparam int DRAIN_CYCLES = 80;
  localparam int SCRIPT_ROWS  = 25;

  // One expected answer of the queue: status code and entry count.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  count;
  } outcome_t;

  // One directed request; when known is set the answer is typed in here,
  // otherwise it comes from the job table model below.
  typedef struct packed {
    logic                kind;
    logic [KEY_W-1:0]    key;
    logic [PID_W-1:0]    pid;
    logic                known;
    logic [STATUS_W-1:0] status;
    logic [ENTRY_W-1:0]  count;
  } script_row_t;

  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // delete on an empty table
    '{REQ_DELETE, 16'h0000, 22'h000000, 1'b1, STATUS_NOT_FOUND, 5'd0},
    // lowest and highest key, lowest and highest pid
    '{REQ_INSERT, 16'h0000, 22'h000000, 1'b1, STATUS_DONE,      5'd1},
    '{REQ_INSERT, 16'hFFFF, 22'h3FFFFF, 1'b1, STATUS_DONE,      5'd2},
    // absent key; pid must be ignored on delete
    '{REQ_DELETE, 16'h1234, 22'h3FFFFF, 1'b1, STATUS_NOT_FOUND, 5'd2},
    // equal keys: each new job goes ahead of the older ones, delete takes the first one
    '{REQ_INSERT, 16'h0100, 22'h000001, 1'b1, STATUS_DONE,      5'd3},
    '{REQ_INSERT, 16'h0100, 22'h000002, 1'b1, STATUS_DONE,      5'd4},
    '{REQ_INSERT, 16'h0100, 22'h000003, 1'b1, STATUS_DONE,      5'd5},
    '{REQ_DELETE, 16'h0100, 22'h000000, 1'b1, STATUS_DONE,      5'd4},
    // fill the table to the top with mixed keys
    '{REQ_INSERT, 16'h8000, 22'h2AAAAA, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'h0001, 22'h155555, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'hFFFE, 22'h3FFFFE, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'h0100, 22'h000004, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'h4000, 22'h200000, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'h7FFF, 22'h1FFFFF, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'h0002, 22'h000010, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'hFFFF, 22'h0F0F0F, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'h0100, 22'h000005, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'h2AAA, 22'h30F0F0, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'h5555, 22'h0000FF, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_INSERT, 16'h0000, 22'h3F0000, 1'b0, STATUS_DONE,      5'd0},
    // table full: insert refused, nothing changes
    '{REQ_INSERT, 16'h1357, 22'h123456, 1'b1, STATUS_FULL,      5'd16},
    '{REQ_DELETE, 16'hFFFF, 22'h000000, 1'b1, STATUS_DONE,      5'd15},
    '{REQ_INSERT, 16'h0000, 22'h3FFFFF, 1'b0, STATUS_DONE,      5'd0},
    '{REQ_DELETE, 16'h0000, 22'h000000, 1'b1, STATUS_DONE,      5'd15},
    '{REQ_DELETE, 16'h9999, 22'h000000, 1'b1, STATUS_NOT_FOUND, 5'd15}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                req_type = REQ_INSERT;
  logic [KEY_W-1:0]    job_key = '0;
  logic [PID_W-1:0]    job_pid = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [ENTRY_W-1:0]  entry_count;

  sorted_job_queue dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .job_key     (job_key),
    .job_pid     (job_pid),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Model of the job table: keys ascending, pids alongside, fill level.
  logic [KEY_W-1:0] tbl_key [QUEUE_DEPTH];
  logic [PID_W-1:0] tbl_pid [QUEUE_DEPTH];
  int               tbl_count = 0;

  outcome_t pending_outcomes [$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 24;
  int       recv_idle_pct = 57;

  // Apply one accepted request to the table model and return the answer
  // the queue must give for it.
  function automatic outcome_t commit_job_request(input logic kind,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [PID_W-1:0] pid);
    outcome_t o;
    int       pos;
    int       hit;
    o.status = STATUS_DONE;
    if (kind == REQ_INSERT) begin
      if (tbl_count >= QUEUE_DEPTH) begin
        o.status = STATUS_FULL;
      end else begin
        // Insert ahead of the first key that is not smaller.
        pos = 0;
        for (int i = 0; i < tbl_count; i++) begin
          if (tbl_key[i] < key) pos++;
        end
        for (int i = tbl_count; i > pos; i--) begin
          tbl_key[i] = tbl_key[i-1];
          tbl_pid[i] = tbl_pid[i-1];
        end
        tbl_key[pos] = key;
        tbl_pid[pos] = pid;
        tbl_count++;
      end
    end else begin
      hit = -1;
      for (int i = 0; i < tbl_count; i++) begin
        if (hit < 0 && tbl_key[i] == key) hit = i;
      end
      if (hit < 0) begin
        o.status = STATUS_NOT_FOUND;
      end else begin
        // Close the gap left by the removed job.
        for (int j = hit; j + 1 < tbl_count; j++) begin
          tbl_key[j] = tbl_key[j+1];
          tbl_pid[j] = tbl_pid[j+1];
        end
        tbl_count--;
      end
    end
    o.count = tbl_count[ENTRY_W-1:0];
    return o;
  endfunction

  // Present one request, hold it until taken, then log its answer.
  // Valid is left high on return so back-to-back requests need no gap between them.
  task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                              input logic [PID_W-1:0] pid, input logic known,
                              input logic [STATUS_W-1:0] want_status,
                              input logic [ENTRY_W-1:0] want_count);
    outcome_t o;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    job_key  <= key;
    job_pid  <= pid;
    do @(posedge clk); while (in_stall);
    o = commit_job_request(kind, key, pid);
    if (known) begin
      o.status = want_status;
      o.count  = want_count;
    end
    pending_outcomes.push_back(o);
  endtask

  // Hold off the sender until every logged answer has come back.
  task automatic drain_outcomes();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // Random requests biased to sweep the fill level between empty and full,
  // with deletes mostly aimed at keys that are stored.
  task automatic random_phase(input int items);
    bit               filling;
    logic             kind;
    logic [KEY_W-1:0] key;
    int               r;
    filling = 1'b1;
    for (int n = 0; n < items; n++) begin
      if (tbl_count >= QUEUE_DEPTH) filling = 1'b0;
      else if (tbl_count == 0) filling = 1'b1;
      kind = ($urandom_range(0, 99) < (filling ? 72 : 28)) ? REQ_INSERT : REQ_DELETE;
      r = $urandom_range(0, 9);
      if (kind == REQ_INSERT) begin
        if (r < 4) key = KEY_W'($urandom_range(0, 7));
        else if (r == 4) key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else key = KEY_W'($urandom());
      end else begin
        if (r < 6 && tbl_count > 0) key = tbl_key[$urandom_range(0, tbl_count - 1)];
        else if (r < 8) key = KEY_W'($urandom_range(0, 7));
        else key = KEY_W'($urandom());
      end
      send_request(kind, key, PID_W'($urandom()), 1'b0, STATUS_DONE, '0);
    end
  endtask

  // Check each taken result against the oldest logged answer; drive the
  // receiver stall for the next edge.
  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: status %0d entry_count %0d", status, entry_count);
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status || entry_count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, entry_count exp %0d got %0d",
                     want.status, status, want.count, entry_count);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table, under sender and receiver idling.
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      send_request(SCRIPT[i].kind, SCRIPT[i].key, SCRIPT[i].pid, SCRIPT[i].known,
                   SCRIPT[i].status, SCRIPT[i].count);
    end
    random_phase(PHASE_ITEMS);
    drain_outcomes();

    // Swap the idling rates.
    send_idle_pct = 57;
    recv_idle_pct = 24;
    random_phase(PHASE_ITEMS);
    drain_outcomes();

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(PHASE_ITEMS);
    drain_outcomes();

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sorted_job_queue.f */
+incdir+rtl
rtl/sjq_pkg.sv
rtl/sjq_store.sv
rtl/sjq_cmp.sv
rtl/sjq_seq.sv
rtl/sorted_job_queue.sv
rtl/sjq_chk.sv
tb/tb.sv
